/* design/pcr_pkg.sv */
package pcr_pkg;

   localparam logic [1:0] OP_HEADER = 2'd0;
   localparam logic [1:0] OP_BYTE   = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;
   localparam logic [1:0] OP_CLEAR  = 2'd3;

   localparam logic [1:0] ST_ACCEPT       = 2'd0;
   localparam logic [1:0] ST_DROP         = 2'd1;
   localparam logic [1:0] ST_NOT_COMPLETE = 2'd2;
   localparam logic [1:0] ST_NO_MORE      = 2'd3;

   // one classified item as it sits in the queue
   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] seq;
      logic [15:0] total;  // already capped at the slot count
      logic [15:0] plen;   // already capped at the payload size
      logic [7:0]  data;
   } cmd_type;

endpackage

/* design/packet_chunk_reassembler.sv */
// packet chunk reassembler: rebuilds a message sent as numbered chunks. a header
// transfer (op 0) claims slot seq_num of up to MAX_SLOTS slots, the first header
// after reset or clear fixing the expected chunk count; payload byte transfers
// (op 1) fill the claimed slot up to its length (capped at MAX_PAYLOAD); read
// transfers (op 2) return the message bytes in slot order once every chunk is in,
// flagging the final byte; a clear (op 3) empties the slot table. every request
// gives exactly one response. requests land in a two-entry queue, so the input
// keeps taking transfers while a response waits, until both entries are full; a
// single sequencer behind it works one item at a time through the slot table and
// the payload memory, each with one write port and one registered read port. a
// read skips empty slots and, on the last byte of a slot, inspects the following
// slots to decide the last flag; a clear sweeps the whole slot table before it
// answers. after reset the slot table is swept before the first request is
// worked on.
module packet_chunk_reassembler #(
   parameter int MAX_SLOTS   = 64,
   parameter int MAX_PAYLOAD = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [15:0] req_seq_num,
   input  logic [15:0] req_total_chunks,
   input  logic [15:0] req_payload_len,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic        rsp_complete,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_out_valid,
   output logic        rsp_last
);
   import pcr_pkg::*;

   // classified request and the queue head
   cmd_type front_cmd;
   cmd_type q_cmd;
   logic    q_valid;
   logic    q_ready;

   // front: caps counts and lengths
   pcr_front #(
      .MAX_SLOTS   (MAX_SLOTS),
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_front (
      .req_op           (req_op),
      .req_seq_num      (req_seq_num),
      .req_total_chunks (req_total_chunks),
      .req_payload_len  (req_payload_len),
      .req_data_byte    (req_data_byte),
      .cmd              (front_cmd)
   );

   // decouples the input side from the sequencer
   pcr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_cmd    (front_cmd),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_cmd   (q_cmd)
   );

   // back: slot table, payload memory, sequencer and response register
   pcr_back #(
      .MAX_SLOTS   (MAX_SLOTS),
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_ready       (q_ready),
      .q_cmd         (q_cmd),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_complete  (rsp_complete),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_out_valid (rsp_out_valid),
      .rsp_last      (rsp_last)
   );

endmodule

/* design/pcr_front.sv */
module pcr_front #(
   parameter int MAX_SLOTS   = 64,
   parameter int MAX_PAYLOAD = 256
) (
   input  logic [1:0]      req_op,
   input  logic [15:0]     req_seq_num,
   input  logic [15:0]     req_total_chunks,
   input  logic [15:0]     req_payload_len,
   input  logic [7:0]      req_data_byte,
   output pcr_pkg::cmd_type cmd
);
   import pcr_pkg::*;

   localparam logic [15:0] SlotCap = 16'(MAX_SLOTS);
   localparam logic [15:0] LenCap  = 16'(MAX_PAYLOAD);

   always_comb begin
      cmd.op    = req_op;
      cmd.seq   = req_seq_num;
      cmd.total = (req_total_chunks > SlotCap) ? SlotCap : req_total_chunks;
      cmd.plen  = (req_payload_len > LenCap) ? LenCap : req_payload_len;
      cmd.data  = req_data_byte;
   end

endmodule

/* design/pcr_queue.sv */
module pcr_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  pcr_pkg::cmd_type in_cmd,
   output logic             out_valid,
   input  logic             out_ready,
   output pcr_pkg::cmd_type out_cmd
);
   import pcr_pkg::*;

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_cmd   = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* design/pcr_back.sv */
module pcr_back #(
   parameter int MAX_SLOTS   = 64,
   parameter int MAX_PAYLOAD = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   output logic             q_ready,
   input  pcr_pkg::cmd_type q_cmd,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [1:0]       rsp_status,
   output logic             rsp_complete,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_out_valid,
   output logic             rsp_last
);
   import pcr_pkg::*;

   localparam int CW    = $clog2(MAX_SLOTS + 1);
   localparam int SW    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int LW    = $clog2(MAX_PAYLOAD + 1);
   localparam int DEPTH = MAX_SLOTS * MAX_PAYLOAD;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam logic [3:0] S_CLR  = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_HDR  = 4'd2;
   localparam logic [3:0] S_BYTE = 4'd3;
   localparam logic [3:0] S_RCHK = 4'd4;
   localparam logic [3:0] S_RLEN = 4'd5;
   localparam logic [3:0] S_RDAT = 4'd6;
   localparam logic [3:0] S_SCHK = 4'd7;
   localparam logic [3:0] S_SLEN = 4'd8;

   // slot table: {received, length}
   logic [LW:0]   slot_mem [MAX_SLOTS];
   logic [LW:0]   sm_rd_ff;
   logic          sm_we;
   logic [SW-1:0] sm_waddr, sm_raddr;
   logic [LW:0]   sm_wdata;

   logic [7:0]    store_mem [DEPTH];
   logic [7:0]    st_rd_ff;
   logic          st_we;
   logic [AW-1:0] st_waddr, st_raddr;

   logic [3:0]    state_ff, state_in;
   cmd_type       cmd_ff, cmd_in;
   logic [CW-1:0] expected_ff, expected_in;
   logic [CW-1:0] received_ff, received_in;
   logic [SW-1:0] fill_slot_ff, fill_slot_in;
   logic [LW-1:0] fill_off_ff, fill_off_in;
   logic [LW-1:0] fill_len_ff, fill_len_in;
   logic          fill_act_ff, fill_act_in;
   logic [CW-1:0] read_slot_ff, read_slot_in;
   logic [LW-1:0] read_off_ff, read_off_in;
   logic [LW-1:0] cur_len_ff, cur_len_in;
   logic [CW-1:0] scan_ff, scan_in;
   logic [SW-1:0] sweep_ff, sweep_in;
   logic          clr_rsp_ff, clr_rsp_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    status_ff, status_in;
   logic          complete_ff, complete_in;
   logic [7:0]    byte_ff, byte_in;
   logic          ovalid_ff, ovalid_in;
   logic          last_ff, last_in;

   logic          out_free;
   logic [CW-1:0] exp_eff;
   logic          hdr_hit;
   logic [LW-1:0] plen_c;
   logic [LW-1:0] sm_len;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_complete  = complete_ff;
   assign rsp_out_byte  = byte_ff;
   assign rsp_out_valid = ovalid_ff;
   assign rsp_last      = last_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign exp_eff  = (expected_ff == '0) ? CW'(cmd_ff.total) : expected_ff;
   assign plen_c   = LW'(cmd_ff.plen);
   assign sm_len   = sm_rd_ff[LW-1:0];
   assign hdr_hit  = (cmd_ff.seq < 16'(exp_eff)) && !sm_rd_ff[LW];

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      expected_in  = expected_ff;
      received_in  = received_ff;
      fill_slot_in = fill_slot_ff;
      fill_off_in  = fill_off_ff;
      fill_len_in  = fill_len_ff;
      fill_act_in  = fill_act_ff;
      read_slot_in = read_slot_ff;
      read_off_in  = read_off_ff;
      cur_len_in   = cur_len_ff;
      scan_in      = scan_ff;
      sweep_in     = sweep_ff;
      clr_rsp_in   = clr_rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      complete_in  = complete_ff;
      byte_in      = byte_ff;
      ovalid_in    = ovalid_ff;
      last_in      = last_ff;
      q_ready      = 1'b0;
      sm_we        = 1'b0;
      sm_waddr     = sweep_ff;
      sm_wdata     = '0;
      sm_raddr     = '0;
      st_we        = 1'b0;
      st_waddr     = AW'(fill_slot_ff) * AW'(MAX_PAYLOAD) + AW'(fill_off_ff);
      st_raddr     = AW'(read_slot_ff) * AW'(MAX_PAYLOAD) + AW'(read_off_ff);

      unique case (state_ff)
         S_CLR: begin
            sm_we    = 1'b1;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == SW'(MAX_SLOTS - 1)) begin
               sweep_in = '0;
               state_in = S_IDLE;
               if (clr_rsp_ff) begin
                  clr_rsp_in   = 1'b0;
                  rsp_valid_in = 1'b1;
                  status_in    = ST_ACCEPT;
                  complete_in  = 1'b1;
                  byte_in      = '0;
                  ovalid_in    = 1'b0;
                  last_in      = 1'b0;
               end
            end
         end
         S_IDLE: begin
            if (q_valid && out_free) begin
               q_ready  = 1'b1;
               cmd_in   = q_cmd;
               sm_raddr = q_cmd.seq[SW-1:0];
               unique case (q_cmd.op)
                  OP_HEADER: state_in = S_HDR;
                  OP_BYTE:   state_in = S_BYTE;
                  OP_READ:   state_in = S_RCHK;
                  OP_CLEAR: begin
                     state_in     = S_CLR;
                     clr_rsp_in   = 1'b1;
                     sweep_in     = '0;
                     expected_in  = '0;
                     received_in  = '0;
                     fill_slot_in = '0;
                     fill_off_in  = '0;
                     fill_act_in  = 1'b0;
                     read_slot_in = '0;
                     read_off_in  = '0;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_HDR: begin
            expected_in  = exp_eff;
            rsp_valid_in = 1'b1;
            byte_in      = '0;
            ovalid_in    = 1'b0;
            last_in      = 1'b0;
            state_in     = S_IDLE;
            if (hdr_hit) begin
               sm_we        = 1'b1;
               sm_waddr     = cmd_ff.seq[SW-1:0];
               sm_wdata     = {1'b1, plen_c};
               received_in  = received_ff + 1'b1;
               fill_slot_in = cmd_ff.seq[SW-1:0];
               fill_off_in  = '0;
               fill_len_in  = plen_c;
               fill_act_in  = (plen_c != '0);
               status_in    = ST_ACCEPT;
               complete_in  = ((received_ff + 1'b1) == exp_eff);
            end else begin
               fill_act_in = 1'b0;
               status_in   = ST_DROP;
               complete_in = (received_ff == exp_eff);
            end
         end
         S_BYTE: begin
            rsp_valid_in = 1'b1;
            complete_in  = (received_ff == expected_ff);
            byte_in      = '0;
            ovalid_in    = 1'b0;
            last_in      = 1'b0;
            state_in     = S_IDLE;
            if (fill_act_ff) begin
               st_we       = 1'b1;
               fill_off_in = fill_off_ff + 1'b1;
               if ((fill_off_ff + 1'b1) >= fill_len_ff) begin
                  fill_act_in = 1'b0;
               end
               status_in = ST_ACCEPT;
            end else begin
               status_in = ST_DROP;
            end
         end
         S_RCHK: begin
            if (received_ff != expected_ff) begin
               rsp_valid_in = 1'b1;
               status_in    = ST_NOT_COMPLETE;
               complete_in  = 1'b0;
               byte_in      = '0;
               ovalid_in    = 1'b0;
               last_in      = 1'b0;
               state_in     = S_IDLE;
            end else if (read_slot_ff >= expected_ff) begin
               rsp_valid_in = 1'b1;
               status_in    = ST_NO_MORE;
               complete_in  = 1'b1;
               byte_in      = '0;
               ovalid_in    = 1'b0;
               last_in      = 1'b0;
               state_in     = S_IDLE;
            end else begin
               sm_raddr = read_slot_ff[SW-1:0];
               state_in = S_RLEN;
            end
         end
         S_RLEN: begin
            if (read_off_ff >= sm_len) begin
               read_slot_in = read_slot_ff + 1'b1;
               read_off_in  = '0;
               state_in     = S_RCHK;
            end else begin
               read_off_in = read_off_ff + 1'b1;
               cur_len_in  = sm_len;
               state_in    = S_RDAT;
            end
         end
         S_RDAT: begin
            byte_in     = st_rd_ff;
            ovalid_in   = 1'b1;
            status_in   = ST_ACCEPT;
            complete_in = 1'b1;
            if (read_off_ff < cur_len_ff) begin
               rsp_valid_in = 1'b1;
               last_in      = 1'b0;
               state_in     = S_IDLE;
            end else begin
               scan_in  = read_slot_ff + 1'b1;
               state_in = S_SCHK;
            end
         end
         S_SCHK: begin
            if (scan_ff >= expected_ff) begin
               rsp_valid_in = 1'b1;
               last_in      = 1'b1;
               state_in     = S_IDLE;
            end else begin
               sm_raddr = scan_ff[SW-1:0];
               state_in = S_SLEN;
            end
         end
         S_SLEN: begin
            if (sm_len != '0) begin
               rsp_valid_in = 1'b1;
               last_in      = 1'b0;
               state_in     = S_IDLE;
            end else begin
               scan_in  = scan_ff + 1'b1;
               state_in = S_SCHK;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (sm_we) begin
         slot_mem[sm_waddr] <= sm_wdata;
      end
      sm_rd_ff <= slot_mem[sm_raddr];
   end

   always_ff @(posedge clock) begin
      if (st_we) begin
         store_mem[st_waddr] <= cmd_ff.data;
      end
      st_rd_ff <= store_mem[st_raddr];
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      fill_len_ff <= fill_len_in;
      cur_len_ff  <= cur_len_in;
      scan_ff     <= scan_in;
      status_ff   <= status_in;
      complete_ff <= complete_in;
      byte_ff     <= byte_in;
      ovalid_ff   <= ovalid_in;
      last_ff     <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         expected_ff  <= '0;
         received_ff  <= '0;
         fill_slot_ff <= '0;
         fill_off_ff  <= '0;
         fill_act_ff  <= 1'b0;
         read_slot_ff <= '0;
         read_off_ff  <= '0;
         sweep_ff     <= '0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         expected_ff  <= expected_in;
         received_ff  <= received_in;
         fill_slot_ff <= fill_slot_in;
         fill_off_ff  <= fill_off_in;
         fill_act_ff  <= fill_act_in;
         read_slot_ff <= read_slot_in;
         read_off_ff  <= read_off_in;
         sweep_ff     <= sweep_in;
         clr_rsp_ff   <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      received_ff <= expected_ff)
      else $error("received count above expected count");

   a_fill_in_range: assert property (@(posedge clock) disable iff (reset)
      fill_act_ff |-> (fill_off_ff < fill_len_ff))
      else $error("fill position past slot length");

   a_read_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_CLR) |-> (read_slot_ff <= expected_ff))
      else $error("read slot beyond expected count");

   a_pop_needs_room: assert property (@(posedge clock) disable iff (reset)
      q_ready |-> !rsp_valid_in || !rsp_valid_ff)
      else $error("item started while a result still blocks the output");
`endif

endmodule

/* dv/packet_chunk_reassembler_test.sv */
module packet_chunk_reassembler_test;
   timeunit 1ns;
   timeprecision 1ps;

   import pcr_pkg::*;

   localparam int NUM_SLOTS = 64;
   localparam int SLOT_BYTES = 256;
   localparam int IDLE_LIMIT = 20000;

   // what one response carries
   typedef struct packed {
      logic [1:0] status;
      logic       complete;
      logic [7:0] out_byte;
      logic       out_valid;
      logic       last;
   } reply_type;

   // scoreboard: mirrors the slot table and payload memory, queues replies
   class reassembly_board;
      int unsigned expected_chunks;
      int unsigned chunks_in;
      bit          got_slot[NUM_SLOTS];
      int unsigned slot_len[NUM_SLOTS];
      logic [7:0]  payload[NUM_SLOTS*SLOT_BYTES];
      int unsigned fill_slot, fill_pos;
      bit          filling;
      int unsigned rd_slot, rd_pos;
      reply_type   pending[$];
      int          errors;
      int          replies;
      int          bytes_out;

      function void wipe();
         expected_chunks = 0;
         chunks_in = 0;
         foreach (got_slot[i]) begin
            got_slot[i] = 0;
            slot_len[i] = 0;
         end
         fill_slot = 0;
         fill_pos = 0;
         filling = 0;
         rd_slot = 0;
         rd_pos = 0;
      endfunction

      function bit more_after(int unsigned s, int unsigned o);
         while (s < expected_chunks) begin
            if (o < slot_len[s]) return 1;
            s++;
            o = 0;
         end
         return 0;
      endfunction

      // note an accepted request, push the reply it must give
      function void note_request(logic [1:0] op, logic [15:0] seq, logic [15:0] total,
                                 logic [15:0] plen, logic [7:0] data);
         reply_type r;
         r = '0;
         r.status = ST_ACCEPT;
         case (op)
            OP_HEADER: begin
               if (expected_chunks == 0)
                  expected_chunks = (total < NUM_SLOTS) ? total : NUM_SLOTS;
               if (seq < expected_chunks && !got_slot[seq]) begin
                  got_slot[seq] = 1;
                  slot_len[seq] = (plen < SLOT_BYTES) ? plen : SLOT_BYTES;
                  chunks_in++;
                  fill_slot = seq;
                  fill_pos = 0;
                  filling = slot_len[seq] != 0;
               end else begin
                  r.status = ST_DROP;
                  filling = 0;
               end
            end
            OP_BYTE: begin
               if (filling && fill_pos < slot_len[fill_slot]) begin
                  payload[fill_slot*SLOT_BYTES + fill_pos] = data;
                  fill_pos++;
                  if (fill_pos >= slot_len[fill_slot]) filling = 0;
               end else begin
                  r.status = ST_DROP;
                  filling = 0;
               end
            end
            OP_READ: begin
               if (chunks_in != expected_chunks) begin
                  r.status = ST_NOT_COMPLETE;
               end else begin
                  while (rd_slot < expected_chunks && rd_pos >= slot_len[rd_slot]) begin
                     rd_slot++;
                     rd_pos = 0;
                  end
                  if (rd_slot >= expected_chunks) begin
                     r.status = ST_NO_MORE;
                  end else begin
                     r.out_byte = payload[rd_slot*SLOT_BYTES + rd_pos];
                     r.out_valid = 1;
                     rd_pos++;
                     r.last = !more_after(rd_slot, rd_pos);
                  end
               end
            end
            default: wipe();
         endcase
         r.complete = chunks_in == expected_chunks;
         pending.push_back(r);
      endfunction

      function void check_reply(reply_type got);
         reply_type exp;
         replies++;
         if (got.out_valid) bytes_out++;
         if (pending.size() == 0) begin
            $display("%0t: unexpected response %p", $realtime, got);
            errors++;
            return;
         end
         exp = pending.pop_front();
         if (got.status !== exp.status) begin
            $display("%0t: status exp %0d got %0d", $realtime, exp.status, got.status);
            errors++;
         end
         if (got.complete !== exp.complete) begin
            $display("%0t: complete exp %0d got %0d", $realtime, exp.complete,
                     got.complete);
            errors++;
         end
         if (got.out_byte !== exp.out_byte) begin
            $display("%0t: out_byte exp %h got %h", $realtime, exp.out_byte,
                     got.out_byte);
            errors++;
         end
         if (got.out_valid !== exp.out_valid) begin
            $display("%0t: out_valid exp %0d got %0d", $realtime, exp.out_valid,
                     got.out_valid);
            errors++;
         end
         if (got.last !== exp.last) begin
            $display("%0t: last exp %0d got %0d", $realtime, exp.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_op;
   logic [15:0] req_seq_num;
   logic [15:0] req_total_chunks;
   logic [15:0] req_payload_len;
   logic [7:0]  req_data_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_status;
   logic        rsp_complete;
   logic [7:0]  rsp_out_byte;
   logic        rsp_out_valid;
   logic        rsp_last;

   reassembly_board board;
   int  idle_cycles;
   bit  stim_done;
   bit  timed_out;
   int  sent;
   // store entries ever written, so reads never touch unwritten bytes
   bit  written[NUM_SLOTS*SLOT_BYTES];

   packet_chunk_reassembler i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_seq_num      (req_seq_num),
      .req_total_chunks (req_total_chunks),
      .req_payload_len  (req_payload_len),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_complete     (rsp_complete),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_out_valid    (rsp_out_valid),
      .rsp_last         (rsp_last)
   );

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // mostly short gaps, now and then a long one, sometimes none at all
   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 45) return 0;
      if (p < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // one request transfer; valid stays up back to back when no gap follows
   task automatic send(logic [1:0] op, logic [15:0] seq, logic [15:0] total,
                       logic [15:0] plen, logic [7:0] data);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end else if (sent == 0) begin
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_seq_num <= seq;
      req_total_chunks <= total;
      req_payload_len <= plen;
      req_data_byte <= data;
      do @(posedge clock); while (!req_ready);
      // transfer happened at this edge
      board.note_request(op, seq, total, plen, data);
      sent++;
   endtask

   // mark store bytes the board wrote (board payload only changes on accepted bytes)
   task automatic byte_item(logic [7:0] d);
      int unsigned s, p;
      bit act;
      s = board.fill_slot;
      p = board.fill_pos;
      act = board.filling;
      send(OP_BYTE, 16'($urandom), 16'($urandom), 16'($urandom), d);
      if (act) written[s*SLOT_BYTES + p] = 1;
   endtask

   // a header followed by its bytes; short marks a truncated chunk
   task automatic chunk(int unsigned seq, int unsigned total, int unsigned len, bit short_it);
      int unsigned n, k;
      send(OP_HEADER, seq[15:0], total[15:0], len[15:0], 8'($urandom));
      n = (len < SLOT_BYTES) ? len : SLOT_BYTES;
      if (board.pending[$].status != ST_ACCEPT) n = $urandom_range(0, 2);
      if (short_it && n > 0) n = $urandom_range(0, n - 1);
      for (k = 0; k < n; k++) byte_item(8'($urandom));
   endtask

   // true when every claimed byte of the message was written at some point
   function automatic bit safe_to_read();
      for (int s = 0; s < board.expected_chunks; s++)
         for (int o = 0; o < board.slot_len[s]; o++)
            if (!written[s*SLOT_BYTES + o]) return 0;
      return 1;
   endfunction

   task automatic send_read();
      send(OP_READ, 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
   endtask

   task automatic drain_reads(int extra);
      int n;
      n = 0;
      for (int s = 0; s < board.expected_chunks; s++) n += board.slot_len[s];
      if (safe_to_read()) begin
         repeat (n + extra) send_read();
      end
   endtask

   // a full message: random order, some duplicates and out-of-range noise
   task automatic message(int unsigned cnt, int unsigned maxlen);
      int unsigned order[$];
      int unsigned s;
      send(OP_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
      for (int i = 0; i < cnt; i++) order.push_back(i);
      order.shuffle();
      foreach (order[i]) begin
         chunk(order[i], cnt, $urandom_range(0, maxlen), $urandom_range(0, 9) == 0);
         if ($urandom_range(0, 5) == 0)
            chunk($urandom_range(0, 99), cnt, $urandom_range(0, 3), 1'b0);
         if ($urandom_range(0, 9) == 0 &&
             (board.chunks_in != board.expected_chunks || safe_to_read()))
            send_read();
         if ($urandom_range(0, 12) == 0)
            byte_item(8'($urandom));
      end
      drain_reads($urandom_range(0, 2));
   endtask

   // response side: random stalls, a few of them long, compare each transfer
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready)
            board.check_reply({rsp_status, rsp_complete, rsp_out_byte, rsp_out_valid,
                               rsp_last});
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if ($urandom_range(0, 99) < 3) begin
            stall_left = $urandom_range(8, 40);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) < 70) || ($urandom_range(0, 3) == 0);
         end
      end
   end

   // watchdog on cycles with no transfer on either side
   initial begin
      idle_cycles = 0;
      timed_out = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else if (!stim_done || board.pending.size() != 0) idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: watchdog expired, %0d replies outstanding",
                     $realtime, board.pending.size());
            $display("packet_chunk_reassembler_test failed");
            $finish;
         end
      end
   end

   initial begin
      board = new();
      board.wipe();
      board.errors = 0;
      board.replies = 0;
      board.bytes_out = 0;
      stim_done = 0;
      sent = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = OP_CLEAR;
      req_seq_num = '0;
      req_total_chunks = '0;
      req_payload_len = '0;
      req_data_byte = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: empty message reads, zero total, extremes of fields
      send(OP_READ, 16'hffff, 16'hffff, 16'hffff, 8'hff);
      send(OP_BYTE, 16'h0, 16'h0, 16'h0, 8'h00);
      chunk(0, 0, 5, 1'b0);
      chunk(65535, 65535, 65535, 1'b0);
      chunk(63, 65535, 0, 1'b0);
      chunk(63, 65535, 2, 1'b0);
      send(OP_READ, '0, '0, '0, '0);
      send(OP_CLEAR, 16'hffff, 16'hffff, 16'hffff, 8'hff);
      chunk(1, 2, 300, 1'b0);
      chunk(0, 7, 1, 1'b0);
      drain_reads(2);
      send(OP_CLEAR, '0, '0, '0, '0);
      chunk(0, 1, 3, 1'b0);
      send(OP_READ, '0, '0, '0, '0);
      byte_item(8'hff);
      drain_reads(1);

      // random: mostly small well-formed messages, a few maxed out
      while (sent < 900) begin
         if (sent < 600 && $urandom_range(0, 29) == 0) message(64, 4);
         else if ($urandom_range(0, 19) == 0) message($urandom_range(1, 3), 60);
         else message($urandom_range(1, 8), 6);
      end
      req_valid <= 1'b0;
      stim_done = 1;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("sent %0d requests, checked %0d responses, %0d message bytes read back",
               sent, board.replies, board.bytes_out);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("packet_chunk_reassembler_test passed");
      else
         $display("packet_chunk_reassembler_test failed");
      $finish;
   end

endmodule
